[rtl/xcc_pkg.sv]
package xcc_pkg;

    // ChaCha constant words ("expand 32-byte k")
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam int WORD_W     = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_WORDS  = 16;
    localparam int NUM_KEYW   = 8;
    // 10 double rounds, 8 row steps each
    localparam int ROUND_STEPS = 80;
    localparam int STEP_CNT_W  = $clog2(ROUND_STEPS);

    // one row of the 4x4 state, lane j = column j
    typedef logic [3:0][WORD_W-1:0] t_row;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0   = 3'd0,
        CFG_KEY_1   = 3'd1,
        CFG_KEY_2   = 3'd2,
        CFG_KEY_3   = 3'd3,
        CFG_NONCE_0 = 3'd4,
        CFG_NONCE_1 = 3'd5,
        CFG_NONCE_2 = 3'd6
    } t_cfg_idx;

    // the four add/xor/rotate steps of a quarter round, applied to whole rows
    typedef enum logic [1:0] {
        QR_AD16 = 2'd0,   // a += b; d ^= a; d <<<= 16
        QR_CB12 = 2'd1,   // c += d; b ^= c; b <<<= 12
        QR_AD8  = 2'd2,   // a += b; d ^= a; d <<<= 8
        QR_CB7  = 2'd3    // c += d; b ^= c; b <<<= 7
    } t_qr_step;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_SUBKEY,
        ST_LOADB,
        ST_FEED,
        ST_EMIT
    } t_state;

endpackage

[rtl/xcc_in_if.sv]
interface xcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       last_byte;

    modport source (output valid, output data_in, output last_byte, input ready);
    modport sink   (input valid, input data_in, input last_byte, output ready);
endinterface

[rtl/xcc_out_if.sv]
interface xcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

[rtl/xcc_row_step.sv]
// Shared round unit: one quarter-round step on all four columns at once.
// x += y; z ^= x; z <<<= n, with n set by the step.
module xcc_row_step (
    input  xcc_pkg::t_row     i_x,
    input  xcc_pkg::t_row     i_y,
    input  xcc_pkg::t_row     i_z,
    input  xcc_pkg::t_qr_step i_step,
    output xcc_pkg::t_row     o_x,
    output xcc_pkg::t_row     o_z
);
    import xcc_pkg::*;

    t_row sum;
    t_row mix;

    // four independent lanes
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            sum[j] = i_x[j] + i_y[j];
            mix[j] = i_z[j] ^ sum[j];
            case (i_step)
                QR_AD16: o_z[j] = {mix[j][15:0], mix[j][31:16]};
                QR_CB12: o_z[j] = {mix[j][19:0], mix[j][31:20]};
                QR_AD8:  o_z[j] = {mix[j][23:0], mix[j][31:24]};
                QR_CB7:  o_z[j] = {mix[j][24:0], mix[j][31:25]};
                default: o_z[j] = mix[j];
            endcase
        end
        o_x = sum;
    end

endmodule

[rtl/xchacha20_stream_cipher.sv]
// XChaCha20 byte stream cipher. Each transfer on i_in is one byte; its result on o_out is
// the byte XORed with the next keystream byte, with the last flag copied. The first byte of
// a message derives the subkey (HChaCha20 over key and nonce words 0..1), then every 64 bytes
// a ChaCha20 block is built with counter 1, 2, ... and nonce word 2. Both use one row-wide
// add/xor/rotate unit, one quarter-round step per cycle, 80 round steps for 20 rounds. A byte
// inside a block is accepted, then loaded into the output register once that is free. A byte
// that opens a new block goes through accept and load, 80 round steps, feed-forward and
// output load; the first byte of a message also goes through subkey derivation (80 more round
// steps, the subkey capture and the block load). The input is not ready while a byte is in
// work; a finished byte can wait in the output register while the next one is taken.
// Configuration (key and nonce words) is written by index and must only change while the
// block is idle; key and nonce words 0..1 are sampled at message start, nonce word 2 at each
// new block.
module xchacha20_stream_cipher (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    xcc_in_if.sink                                   i_in,
    xcc_out_if.source                                o_out,
    input  logic                                     i_cfg_we,
    input  logic [xcc_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [xcc_pkg::CFG_W-1:0]                i_cfg_data
);
    import xcc_pkg::*;

    // control registers
    t_state                r_state,   n_state;
    logic [STEP_CNT_W-1:0] r_cnt,     n_cnt;
    logic                  r_hmode,   n_hmode;
    logic                  r_in_msg,  n_in_msg;
    logic [WORD_W-1:0]     r_counter, n_counter;
    logic [5:0]            r_pos,     n_pos;
    logic                  r_out_valid, n_out_valid;

    // payload registers
    logic [WORD_W-1:0] r_w [NUM_WORDS];
    logic [WORD_W-1:0] n_w [NUM_WORDS];
    logic [WORD_W-1:0] r_subkey [NUM_KEYW];
    logic [WORD_W-1:0] n_subkey [NUM_KEYW];
    logic [7:0]        r_data,     n_data;
    logic              r_last,     n_last;
    logic [7:0]        r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    // configuration
    logic [CFG_W-1:0] r_key [4];
    logic [CFG_W-1:0] r_nonce [3];

    // datapath signals
    logic [WORD_W-1:0] h_init  [NUM_WORDS];
    logic [WORD_W-1:0] b_init  [NUM_WORDS];
    logic [WORD_W-1:0] ff_w    [NUM_WORDS];
    logic [WORD_W-1:0] step_w  [NUM_WORDS];
    t_row              cur     [4];
    t_row              upd     [4];
    t_row              shuf    [4];
    t_row              su_x, su_y, su_z, su_nx, su_nz;
    t_qr_step          step;
    logic              sel_cb;
    logic [WORD_W-1:0] ks_word;
    logic [7:0]        ks_byte;
    logic              out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            for (int i = 0; i < 3; i++) r_nonce[i] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_0:   r_key[0]   <= i_cfg_data;
                CFG_KEY_1:   r_key[1]   <= i_cfg_data;
                CFG_KEY_2:   r_key[2]   <= i_cfg_data;
                CFG_KEY_3:   r_key[3]   <= i_cfg_data;
                CFG_NONCE_0: r_nonce[0] <= i_cfg_data;
                CFG_NONCE_1: r_nonce[1] <= i_cfg_data;
                CFG_NONCE_2: r_nonce[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // initial states: HChaCha20 and ChaCha20 block
    always_comb begin
        h_init[0] = SIGMA_0;
        h_init[1] = SIGMA_1;
        h_init[2] = SIGMA_2;
        h_init[3] = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            h_init[4 + 2*i] = r_key[i][31:0];
            h_init[5 + 2*i] = r_key[i][63:32];
        end
        h_init[12] = r_nonce[0][31:0];
        h_init[13] = r_nonce[0][63:32];
        h_init[14] = r_nonce[1][31:0];
        h_init[15] = r_nonce[1][63:32];

        b_init[0] = SIGMA_0;
        b_init[1] = SIGMA_1;
        b_init[2] = SIGMA_2;
        b_init[3] = SIGMA_3;
        for (int i = 0; i < NUM_KEYW; i++) b_init[4 + i] = r_subkey[i];
        b_init[12] = r_counter;
        b_init[13] = '0;
        b_init[14] = r_nonce[2][31:0];
        b_init[15] = r_nonce[2][63:32];

        // feed-forward add, lanes independent
        for (int i = 0; i < NUM_WORDS; i++) ff_w[i] = r_w[i] + b_init[i];
    end

    // operand rows for the shared unit
    assign step   = t_qr_step'(r_cnt[1:0]);
    assign sel_cb = step inside {QR_CB12, QR_CB7};

    always_comb begin
        for (int r = 0; r < 4; r++)
            for (int j = 0; j < 4; j++) cur[r][j] = r_w[4*r + j];
        su_x = sel_cb ? cur[2] : cur[0];
        su_y = sel_cb ? cur[3] : cur[1];
        su_z = sel_cb ? cur[1] : cur[3];
    end

    xcc_row_step u_step (
        .i_x    (su_x),
        .i_y    (su_y),
        .i_z    (su_z),
        .i_step (step),
        .o_x    (su_nx),
        .o_z    (su_nz)
    );

    // write-back; after the last step of a round, rotate row r by r lanes
    // (left to move to diagonals, right to move back to columns)
    always_comb begin
        for (int r = 0; r < 4; r++) upd[r] = cur[r];
        if (sel_cb) begin
            upd[2] = su_nx;
            upd[1] = su_nz;
        end else begin
            upd[0] = su_nx;
            upd[3] = su_nz;
        end
        for (int r = 0; r < 4; r++)
            for (int j = 0; j < 4; j++)
                if (!r_cnt[2]) shuf[r][j] = upd[r][2'(j + r)];
                else           shuf[r][j] = upd[r][2'(j - r)];
        for (int r = 0; r < 4; r++)
            for (int j = 0; j < 4; j++)
                step_w[4*r + j] = (step == QR_CB7) ? shuf[r][j] : upd[r][j];
    end

    // keystream byte: the state words hold the finished block
    assign ks_word = r_w[r_pos[5:2]];
    assign ks_byte = ks_word[8*r_pos[1:0] +: 8];

    assign out_free = !r_out_valid || o_out.ready;

    // sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_hmode     = r_hmode;
        n_in_msg    = r_in_msg;
        n_counter   = r_counter;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_data      = r_data;
        n_last      = r_last;
        n_w         = r_w;
        n_subkey    = r_subkey;

        // result taken downstream
        if (r_out_valid && o_out.ready) n_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_data = i_in.data_in;
                    n_last = i_in.last_byte;
                    if (!r_in_msg) begin
                        // message start: derive the subkey first
                        n_w       = h_init;
                        n_hmode   = 1'b1;
                        n_cnt     = '0;
                        n_in_msg  = 1'b1;
                        n_counter = 32'd1;
                        n_pos     = '0;
                        n_state   = ST_ROUND;
                    end else if (r_pos == '0) begin
                        n_w     = b_init;
                        n_hmode = 1'b0;
                        n_cnt   = '0;
                        n_state = ST_ROUND;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_ROUND: begin
                n_w   = step_w;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(ROUND_STEPS - 1))
                    n_state = r_hmode ? ST_SUBKEY : ST_FEED;
            end
            ST_SUBKEY: begin
                // HChaCha20 output: rows 0 and 3, no feed-forward
                for (int i = 0; i < 4; i++) begin
                    n_subkey[i]     = r_w[i];
                    n_subkey[4 + i] = r_w[12 + i];
                end
                n_state = ST_LOADB;
            end
            ST_LOADB: begin
                n_w     = b_init;
                n_hmode = 1'b0;
                n_cnt   = '0;
                n_state = ST_ROUND;
            end
            ST_FEED: begin
                n_w       = ff_w;
                n_counter = r_counter + 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ ks_byte;
                    n_out_last  = r_last;
                    n_pos       = r_pos + 1'b1;
                    if (r_last) n_in_msg = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_hmode     <= 1'b0;
            r_in_msg    <= 1'b0;
            r_counter   <= 32'd1;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_hmode     <= n_hmode;
            r_in_msg    <= n_in_msg;
            r_counter   <= n_counter;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_subkey   <= n_subkey;
        r_data     <= n_data;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;
    assign o_out.last_out = r_out_last;

endmodule

[rtl/xcc_checker.sv]
module xcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data,
    input logic       i_out_last
);
    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_pend;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // bytes accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without an accepted byte");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two bytes in flight");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind xchacha20_stream_cipher xcc_checker u_xcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data_out),
    .i_out_last  (o_out.last_out)
);
